[rtl/ibs_pkg.sv]
package ibs_pkg;

  localparam int CW   = 32;        // coordinate width
  localparam int RW   = CW - 1;    // radius width
  localparam int MW   = CW + 1;    // magnitude of a coordinate difference
  localparam int EW   = CW + 2;    // dist + r, excess, divisor
  localparam int SQW  = 2 * CW + 2; // sum of three squares
  localparam int NUMW = MW + EW;   // |d| * excess
  localparam int RTW  = SQW / 2;   // root width

  localparam logic [RW-1:0] RMAX = {RW{1'b1}};

endpackage

[rtl/ibs_sqrt.sv]
module ibs_sqrt
  import ibs_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [SQW-1:0] n,
  output logic [RTW-1:0] root,
  output logic           done
);

  localparam int CNTW = $clog2(RTW);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [SQW-1:0]  sh;
  logic [RTW+1:0]  rem;
  logic [RTW+3:0]  tmp;
  logic [RTW+3:0]  trial;
  logic            ge;
  logic [RTW+1:0]  rem_next;

  // two radicand bits per step, one root bit out
  always_comb begin
    tmp      = {rem, sh[SQW-1 -: 2]};
    trial    = {2'b00, root, 2'b01};
    ge       = tmp >= trial;
    rem_next = ge ? (RTW + 2)'(tmp - trial) : tmp[RTW+1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(RTW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh   <= n;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      sh   <= {sh[SQW-3:0], 2'b00};
      rem  <= rem_next;
      root <= {root[RTW-2:0], ge};
    end
  end

endmodule

[rtl/ibs_div.sv]
module ibs_div
  import ibs_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [NUMW-1:0] num,
  input  logic [EW-1:0]   den,
  output logic [EW-1:0]   quot,
  output logic            done
);

  localparam int CNTW = $clog2(EW);

  logic            busy;
  logic [CNTW-1:0] cnt;
  logic [EW-1:0]   sh;
  logic [EW-1:0]   rem;
  logic [EW:0]     tmp;
  logic            ge;
  logic [EW-1:0]   rem_next;

  // quotient is known to fit EW bits, so the top of num starts the remainder
  always_comb begin
    tmp      = {rem, sh[EW-1]};
    ge       = tmp >= {1'b0, den};
    rem_next = ge ? EW'(tmp - {1'b0, den}) : tmp[EW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(EW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= EW'(num[NUMW-1:EW]);
      sh   <= num[EW-1:0];
      quot <= '0;
    end else if (busy) begin
      rem  <= rem_next;
      sh   <= {sh[EW-2:0], 1'b0};
      quot <= {quot[EW-2:0], ge};
    end
  end

endmodule

[rtl/incremental_bounding_sphere.sv]
// Incremental bounding sphere.
// Input stream s_axis: one member sphere per item (center signed Q16.16,
// radius unsigned Q15.16). s_axis_tuser flags first_in_pass (starts a new
// bound) and clear_best (forget the best bound); s_axis_tlast ends the pass.
// Output stream m_axis: one item per pass, at the item with tlast: the pass
// bound, the smallest bound so far, and a flag in m_axis_tuser that some
// radius or center clipped since the last first_in_pass item.
// A first_in_pass item goes straight to the finish state. Any other item is
// absorbed by one 34x34 multiplier, a bit-serial square root (33 steps) and
// a bit-serial divider (34 steps, run once per axis); the divider runs only
// when the bound grows and the new center differs from the old one.
// s_axis_tready is high only between items. The output item sits in a
// register; the next input is accepted while it waits, and the block holds
// at the end of the next pass until m_axis_tready takes the pending item.
// Reset: running bound zero at the origin, best radius maximal, flag clear,
// no output pending.
module incremental_bounding_sphere
  import ibs_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // sphere_x, sphere_y, sphere_z, sphere_radius, zero pad
  input  logic [127:0] s_axis_tdata,
  // first_in_pass, clear_best
  input  logic [1:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pass_center_x/y/z, pass_radius, best_center_x/y/z, best_radius, zero pad
  output logic [255:0] m_axis_tdata,
  // radius or center clipped since the last first_in_pass
  output logic [0:0]   m_axis_tuser
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SQ     = 8'b0000_0010,
    S_SQRT   = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_MUL    = 8'b0001_0000,
    S_DIV    = 8'b0010_0000,
    S_APPLY  = 8'b0100_0000,
    S_FINISH = 8'b1000_0000
  } state_t;

  state_t state;

  logic signed [CW-1:0] run_c [3];
  logic [RW-1:0]        run_r;
  logic signed [CW-1:0] best_c [3];
  logic [RW-1:0]        best_r;
  logic                 sat;
  logic                 last_q;

  logic signed [CW-1:0] in_c [3];
  logic [RW-1:0]        in_r;
  logic [RW-1:0]        mem_r;
  logic [MW-1:0]        dmag [3];
  logic                 dneg [3];
  logic [MW-1:0]        dmag_in [3];
  logic                 dneg_in [3];

  logic [2:0]           cnt;
  logic [1:0]           axis;
  logic [SQW-1:0]       acc;
  logic [2*EW-1:0]      prod;
  logic [EW-1:0]        mul_a;
  logic [EW-1:0]        mul_b;
  logic [EW-1:0]        excess;
  logic [RTW-1:0]       span;
  logic                 div_go;

  logic                 sqrt_start;
  logic [RTW-1:0]       sqrt_root;
  logic                 sqrt_done;
  logic [EW-1:0]        div_q;
  logic                 div_done;

  logic [EW-1:0]        sum;
  logic [EW:0]          nr_full;
  logic [EW-1:0]        nr;
  logic signed [EW:0]   cv;
  logic                 c_hi;
  logic                 c_lo;
  logic                 out_free;
  logic                 emit;
  logic                 replace;

  assign in_c[0] = s_axis_tdata[31:0];
  assign in_c[1] = s_axis_tdata[63:32];
  assign in_c[2] = s_axis_tdata[95:64];
  assign in_r    = s_axis_tdata[126:96];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [MW-1:0] d;
      d          = {in_c[k][CW-1], in_c[k]} - {run_c[k][CW-1], run_c[k]};
      dneg_in[k] = d[MW-1];
      dmag_in[k] = d[MW-1] ? MW'(-d) : MW'(d);
    end
  end

  assign s_axis_tready = (state == S_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign emit          = (state == S_FINISH) && last_q && out_free;
  assign sqrt_start    = (state == S_SQ) && (cnt == 3'd4);

  // shared multiplier operands
  always_comb begin
    mul_a = EW'(dmag[axis]);
    mul_b = (state == S_MUL) ? excess : EW'(dmag[axis]);
  end

  always_comb begin
    sum     = EW'(span) + EW'(mem_r);
    nr_full = {1'b0, sum} + (EW + 1)'(run_r);
    nr      = nr_full[EW:1];
    cv      = dneg[axis] ? (EW + 1)'(run_c[axis]) - (EW + 1)'(div_q)
                         : (EW + 1)'(run_c[axis]) + (EW + 1)'(div_q);
    c_hi    = cv > (EW + 1)'(signed'({1'b0, RMAX}));
    c_lo    = cv < -((EW + 1)'(signed'({1'b0, RMAX}))) - 1;
    replace = run_r < best_r;
  end

  ibs_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .n     (acc),
    .root  (sqrt_root),
    .done  (sqrt_done)
  );

  ibs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (prod[NUMW-1:0]),
    .den   ({span, 1'b0}),
    .quot  (div_q),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      run_c[0]      <= '0;
      run_c[1]      <= '0;
      run_c[2]      <= '0;
      run_r         <= '0;
      best_c[0]     <= '0;
      best_c[1]     <= '0;
      best_c[2]     <= '0;
      best_r        <= RMAX;
      sat           <= 1'b0;
      m_axis_tvalid <= 1'b0;
      div_go        <= 1'b0;
      cnt           <= '0;
      axis          <= '0;
    end else begin
      div_go <= 1'b0;
      if (emit) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            last_q <= s_axis_tlast;
            mem_r  <= in_r;
            if (s_axis_tuser[1]) begin
              best_c[0] <= '0;
              best_c[1] <= '0;
              best_c[2] <= '0;
              best_r    <= RMAX;
            end
            if (s_axis_tuser[0]) begin
              run_c[0] <= in_c[0];
              run_c[1] <= in_c[1];
              run_c[2] <= in_c[2];
              run_r    <= in_r;
              sat      <= 1'b0;
              state    <= S_FINISH;
            end else begin
              for (int k = 0; k < 3; k++) begin
                dmag[k] <= dmag_in[k];
                dneg[k] <= dneg_in[k];
              end
              acc   <= '0;
              cnt   <= '0;
              axis  <= '0;
              state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          // product of one axis, accumulated in the next cycle
          prod <= mul_a * mul_b;
          if (cnt != 3'd0) acc <= acc + SQW'(prod);
          if (cnt < 3'd2) axis <= axis + 1'b1;
          cnt <= cnt + 1'b1;
          if (cnt == 3'd4) state <= S_SQRT;
        end
        S_SQRT: begin
          if (sqrt_done) begin
            span  <= sqrt_root;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          axis <= '0;
          if (sum <= EW'(run_r)) begin
            state <= S_FINISH;
          end else if (span == '0) begin
            run_r <= mem_r;
            state <= S_FINISH;
          end else begin
            excess <= sum - EW'(run_r);
            if (nr > EW'(RMAX)) begin
              run_r <= RMAX;
              sat   <= 1'b1;
            end else begin
              run_r <= RW'(nr);
            end
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod   <= mul_a * mul_b;
          div_go <= 1'b1;
          state  <= S_DIV;
        end
        S_DIV: begin
          if (div_done) state <= S_APPLY;
        end
        S_APPLY: begin
          if (c_hi) begin
            run_c[axis] <= signed'({1'b0, RMAX});
            sat         <= 1'b1;
          end else if (c_lo) begin
            run_c[axis] <= signed'({1'b1, RW'(0)});
            sat         <= 1'b1;
          end else begin
            run_c[axis] <= CW'(cv);
          end
          if (axis == 2'd2) begin
            state <= S_FINISH;
          end else begin
            axis  <= axis + 1'b1;
            state <= S_MUL;
          end
        end
        S_FINISH: begin
          if (!last_q) begin
            state <= S_IDLE;
          end else if (out_free) begin
            if (replace) begin
              best_r    <= run_r;
              best_c[0] <= run_c[0];
              best_c[1] <= run_c[1];
              best_c[2] <= run_c[2];
            end
            m_axis_tdata <= {2'b00,
              replace ? run_r    : best_r,
              replace ? run_c[2] : best_c[2],
              replace ? run_c[1] : best_c[1],
              replace ? run_c[0] : best_c[0],
              run_r, run_c[2], run_c[1], run_c[0]};
            m_axis_tuser <= sat;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // quotient of a center shift never exceeds half of span + r
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_done) |-> !div_q[EW-1])
    else $error("center shift out of range");

  a_sqrt_owner: assert property (@(posedge clk) disable iff (rst)
    sqrt_done |-> state == S_SQRT)
    else $error("root finished outside its wait state");

  a_best_le_pass: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> m_axis_tdata[253:223] <= m_axis_tdata[126:96])
    else $error("best radius above pass radius");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_go |-> state == S_DIV)
    else $error("divider started outside its wait state");

endmodule

[tb/incremental_bounding_sphere_test.sv]
module incremental_bounding_sphere_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CMAX = 64'sd2147483647;
  localparam longint CMIN = -64'sd2147483648;
  localparam longint unsigned RADMAX = 64'd2147483647;

  typedef struct packed {
    logic        sat;
    logic [30:0] br;
    logic [31:0] bcz, bcy, bcx;
    logic [30:0] pr;
    logic [31:0] pcz, pcy, pcx;
  } bound_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [255:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  incremental_bounding_sphere uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint          run_x, run_y, run_z, best_x, best_y, best_z;
  longint unsigned run_rad, best_rad;
  bit              clip_flag;

  bound_t bounds_due[$];
  int     mismatches = 0;
  bit     failed = 1'b0;
  bit     tx_steady = 1'b0;
  bit     rx_steady = 1'b0;
  int     rx_holdoff = 0;
  int     sent = 0;

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic logic [127:0] wide_sq(longint v);
    logic [127:0] m;
    m = {64'b0, mag(v)};
    return m * m;
  endfunction

  function automatic longint unsigned floor_root(logic [127:0] n);
    logic [127:0] acc, c;
    acc = '0;
    for (int b = 63; b >= 0; b--) begin
      c = acc | (128'd1 << b);
      if (c * c <= n) acc = c;
    end
    return acc[63:0];
  endfunction

  function longint shifted_coord(longint c, longint d, longint unsigned e,
                                 longint unsigned den);
    logic [127:0] q;
    longint v;
    q = ({64'b0, mag(d)} * {64'b0, e}) / {64'b0, den};
    if (q > (128'd1 << 62)) q = 128'd1 << 62;
    v = d < 0 ? c - longint'(q[63:0]) : c + longint'(q[63:0]);
    if (v > CMAX) begin
      clip_flag = 1'b1;
      return CMAX;
    end
    if (v < CMIN) begin
      clip_flag = 1'b1;
      return CMIN;
    end
    return v;
  endfunction

  function void grow_bound(longint x, longint y, longint z, longint unsigned r);
    longint dx, dy, dz;
    longint unsigned span, e, nr;
    dx = x - run_x;
    dy = y - run_y;
    dz = z - run_z;
    span = floor_root(wide_sq(dx) + wide_sq(dy) + wide_sq(dz));
    if (span + r <= run_rad) return;
    if (span == 0) begin
      run_rad = r;
      return;
    end
    e = span + r - run_rad;
    run_x = shifted_coord(run_x, dx, e, 2 * span);
    run_y = shifted_coord(run_y, dy, e, 2 * span);
    run_z = shifted_coord(run_z, dz, e, 2 * span);
    nr = (span + r + run_rad) >> 1;
    if (nr > RADMAX) begin
      nr = RADMAX;
      clip_flag = 1'b1;
    end
    run_rad = nr;
  endfunction

  function void predict_sphere(logic signed [31:0] x, y, z, logic [30:0] r,
                               bit first, bit last, bit clr);
    bound_t b;
    if (clr) begin
      best_x = 0;
      best_y = 0;
      best_z = 0;
      best_rad = RADMAX;
    end
    if (first) begin
      run_x = x;
      run_y = y;
      run_z = z;
      run_rad = r;
      clip_flag = 1'b0;
    end else begin
      grow_bound(x, y, z, r);
    end
    if (!last) return;
    if (run_rad < best_rad) begin
      best_rad = run_rad;
      best_x = run_x;
      best_y = run_y;
      best_z = run_z;
    end
    b.pcx = run_x[31:0];
    b.pcy = run_y[31:0];
    b.pcz = run_z[31:0];
    b.pr  = run_rad[30:0];
    b.bcx = best_x[31:0];
    b.bcy = best_y[31:0];
    b.bcz = best_z[31:0];
    b.br  = best_rad[30:0];
    b.sat = clip_flag;
    bounds_due.push_back(b);
  endfunction

  task automatic send_sphere(logic signed [31:0] x, y, z, logic [30:0] r,
                             bit first, bit last, bit clr = 1'b0);
    if (!tx_steady && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, r, z, y, x};
    s_axis_tuser  <= {clr, first};
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_sphere(x, y, z, r, first, last, clr);
    sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (bounds_due.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (rx_holdoff > 0) m_axis_tready <= 1'b0;
    else if (rx_steady) m_axis_tready <= 1'b1;
    else m_axis_tready <= $urandom_range(99) >= 34;
  end

  always @(posedge clk) begin
    if (rx_holdoff > 0) rx_holdoff <= rx_holdoff - 1;
  end

  always @(posedge clk) begin
    bound_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser, m_axis_tdata[253:0]};
      if (bounds_due.size() == 0) begin
        failed = 1'b1;
        if (mismatches++ < 10) $display("unexpected output item %h", got);
      end else begin
        want = bounds_due.pop_front();
        if (got !== want) begin
          failed = 1'b1;
          if (mismatches++ < 10)
            $display("bound mismatch: expected %h got %h", want, got);
        end
      end
    end
  end

  task automatic test_no_pass_started();
    // absorbed into the zero bound left by reset
    send_sphere(32'sh0003_0000, -32'sh0004_0000, 0, 31'h0001_0000, 0, 0);
    send_sphere(32'sh0010_0000, 32'sh0001_0000, 32'sh0002_0000, 31'h0000_8000, 0, 1);
  endtask

  task automatic test_directed();
    send_sphere(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 31'h7fff_ffff, 1, 1);
    send_sphere(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 31'd1, 1, 1, 1);
    send_sphere(0, 0, 0, 31'h0002_0000, 1, 0);
    send_sphere(32'sh0000_8000, 0, 0, 31'h0000_4000, 0, 0);     // contained
    send_sphere(0, 0, 0, 31'h0005_0000, 0, 0);                  // coincident, larger
    send_sphere(0, 0, 0, 31'h0001_0000, 0, 0);                  // coincident, smaller
    send_sphere(32'sh0008_0000, 32'sh0003_0000, -32'sh0002_0000, 31'h0001_0000, 0, 1);
    // tie with the best radius does not replace it
    send_sphere(32'sh0100_0000, 0, 0, 31'h0001_0000, 1, 1, 1);
    send_sphere(32'sh0200_0000, 0, 0, 31'h0001_0000, 1, 1);
    send_sphere(32'sh0300_0000, 0, 0, 31'h0000_8000, 1, 0);
    send_sphere(32'sh0300_0000, 32'sh0000_0010, 0, 31'd0, 0, 1); // zero radius
    // radius overflow
    send_sphere(32'sh8000_0000, 0, 0, 31'h7fff_ffff, 1, 0);
    send_sphere(32'sh7fff_ffff, 0, 0, 31'h7fff_ffff, 0, 1);
    // radius overflow again, then flag kept without a new first
    send_sphere(0, 0, 0, 31'd1, 1, 0);
    send_sphere(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 31'h7fff_ffff, 0, 1);
    send_sphere(32'sh7fff_0000, 0, 0, 31'd5, 0, 1);
    send_sphere(-32'sh7fff_0000, -32'sh0100_0000, 32'sh0000_0001, 31'd3, 1, 1);
  endtask

  function automatic logic [31:0] rand_coord(logic [31:0] base, int spread);
    case ($urandom_range(3))
      0: return $urandom;
      default: return base + ($urandom_range(2 * spread) - spread);
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(3))
      0: return 31'($urandom_range(32'h7fff_ffff, 1));
      1: return 31'($urandom_range(32'h00ff_ffff, 1));
      default: return 31'($urandom_range(32'h0004_0000, 1));
    endcase
  endfunction

  task automatic random_pass(int len);
    logic [31:0] bx, by, bz;
    int spread;
    bx = $urandom;
    by = $urandom;
    bz = $urandom;
    spread = $urandom_range(1) ? 32'h0010_0000 : 32'h0000_1000;
    for (int i = 0; i < len; i++) begin
      send_sphere(rand_coord(bx, spread), rand_coord(by, spread),
                  rand_coord(bz, spread), rand_radius(),
                  i == 0 ? ($urandom_range(19) != 0) : ($urandom_range(29) == 0),
                  i == len - 1, $urandom_range(11) == 0);
    end
  endtask

  task automatic test_backpressure();
    wait_drained();
    rx_holdoff = 1500;
    for (int i = 0; i < 6; i++) random_pass($urandom_range(1, 3));
  endtask

  task automatic test_drain_pause();
    random_pass(4);
    wait_drained();
    random_pass(3);
  endtask

  task automatic test_random(int target);
    while (sent < target) begin
      tx_steady = (sent % 400) > 300;
      rx_steady = tx_steady;
      random_pass($urandom_range(1, 6));
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    run_x = 0;
    run_y = 0;
    run_z = 0;
    run_rad = 0;
    best_x = 0;
    best_y = 0;
    best_z = 0;
    best_rad = RADMAX;
    clip_flag = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_no_pass_started();
    test_directed();
    test_backpressure();
    test_drain_pause();
    test_random(1600);
    wait_drained();
    repeat (300) @(posedge clk);
    if (!failed && bounds_due.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

endmodule
